// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; compiled out under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Plain property, checked at every clock edge outside reset.
`define MBB_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Implication: antecedent at one edge, consequent at the next.
`define MBB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define MBB_ASSERT(label, clk, rst, prop)
`define MBB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== src/mbb_pkg.sv =====
// ----------------------------------------------------------------------------
// mbb_pkg
// Types, constants and helpers for the monochrome bitmap blit.
// ----------------------------------------------------------------------------
package mbb_pkg;

  localparam int DISP_WIDTH  = 540;
  localparam int DISP_HEIGHT = 960;

  localparam int COORD_W   = 10;
  localparam int COL_W     = 7;
  localparam int ROW_W     = 10;
  localparam int ADDR_W    = 20;
  localparam int BYTE_W    = 8;
  localparam int PIX_W     = 2;
  localparam int PIXELS_W  = BYTE_W * PIX_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [PIX_W-1:0] BLACK_CODE = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_WIDTH_BYTES = 3'd2,
    REG_HEIGHT      = 3'd3,
    REG_TRANSPARENT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [COL_W-1:0]   image_width_bytes;
    logic [ROW_W-1:0]   image_height;
    logic               transparent_mode;
  } cfg_t;

  // Captured request: source byte plus the counter position it belongs to.
  typedef struct packed {
    logic [BYTE_W-1:0] src_byte;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   base_address;
    logic [PIXELS_W-1:0] pixels;
    logic [BYTE_W-1:0]   write_mask;
    logic                last_of_image;
  } res_t;

  // Source bit 1 is white (code 0), bit 0 is black; MSB is pixel 0.
  function automatic logic [PIXELS_W-1:0] expand_pixels(input logic [BYTE_W-1:0] b);
    logic [PIXELS_W-1:0] px;
    px = '0;
    for (int j = 0; j < BYTE_W; j++) begin
      if (!b[BYTE_W-1-j]) begin
        px[PIX_W*j +: PIX_W] = BLACK_CODE;
      end
    end
    return px;
  endfunction

endpackage

// ===== src/mbb_if.sv =====
// ----------------------------------------------------------------------------
// mbb_if
// Valid/ready channels for source bytes and framebuffer write requests.
// ----------------------------------------------------------------------------
interface mbb_src_if;
  logic                        valid;
  logic                        ready;
  logic [mbb_pkg::BYTE_W-1:0]  src_byte;

  modport source (output valid, output src_byte, input ready);
  modport sink   (input valid, input src_byte, output ready);
endinterface

interface mbb_dst_if;
  logic                          valid;
  logic                          ready;
  logic [mbb_pkg::ADDR_W-1:0]    base_address;
  logic [mbb_pkg::PIXELS_W-1:0]  pixels;
  logic [mbb_pkg::BYTE_W-1:0]    write_mask;
  logic                          last_of_image;

  modport source (output valid, output base_address, output pixels,
                  output write_mask, output last_of_image, input ready);
  modport sink   (input valid, input base_address, input pixels,
                  input write_mask, input last_of_image, output ready);
endinterface

// ===== src/mbb_ctr.sv =====
// ----------------------------------------------------------------------------
// mbb_ctr
// Source column/row position counters, wrapping at the image bounds.
// ----------------------------------------------------------------------------
module mbb_ctr (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  mbb_pkg::cfg_t               cfg,
  output logic [mbb_pkg::COL_W-1:0]   column,
  output logic [mbb_pkg::ROW_W-1:0]   row
);

  logic [mbb_pkg::COL_W-1:0] column_next;
  logic [mbb_pkg::ROW_W-1:0] row_next;
  logic                      empty;
  logic [mbb_pkg::COL_W:0]   col_inc;
  logic [mbb_pkg::ROW_W:0]   row_inc;

  always_comb begin
    empty   = (cfg.image_width_bytes == '0) || (cfg.image_height == '0);
    col_inc = {1'b0, column} + 1'b1;
    row_inc = {1'b0, row} + 1'b1;
    column_next = column;
    row_next    = row;
    if (empty) begin
      column_next = '0;
      row_next    = '0;
    end else if (col_inc >= {1'b0, cfg.image_width_bytes}) begin
      column_next = '0;
      if (row_inc >= {1'b0, cfg.image_height}) begin
        row_next = '0;
      end else begin
        row_next = row_inc[mbb_pkg::ROW_W-1:0];
      end
    end else begin
      column_next = col_inc[mbb_pkg::COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
    end else if (advance) begin
      column <= column_next;
      row    <= row_next;
    end
  end

endmodule

// ===== src/mbb_calc.sv =====
// ----------------------------------------------------------------------------
// mbb_calc
// Address, pixel expansion and clip mask for one captured source byte.
// ----------------------------------------------------------------------------
module mbb_calc (
  input  mbb_pkg::req_t  req,
  input  mbb_pkg::cfg_t  cfg,
  output mbb_pkg::res_t  res
);

  localparam int Y_W = mbb_pkg::COORD_W + 1;
  localparam int X_W = mbb_pkg::COORD_W + 1;
  localparam int P_W = mbb_pkg::ADDR_W + 2;

  logic [Y_W-1:0] dest_y;
  logic [X_W-1:0] x0;
  logic [P_W-1:0] base_full;
  logic           in_image;
  logic           row_visible;
  logic [mbb_pkg::BYTE_W-1:0] mask;

  always_comb begin
    dest_y = Y_W'(cfg.origin_y) + Y_W'(req.row);
    x0     = X_W'(cfg.origin_x) + X_W'({req.column, 3'b000});
    base_full = P_W'(dest_y) * P_W'(mbb_pkg::DISP_WIDTH) + P_W'(x0);

    in_image = (cfg.image_width_bytes != '0) && (cfg.image_height != '0) &&
               (req.column < cfg.image_width_bytes) && (req.row < cfg.image_height);
    row_visible = dest_y < Y_W'(mbb_pkg::DISP_HEIGHT);

    mask = '0;
    for (int j = 0; j < mbb_pkg::BYTE_W; j++) begin
      mask[j] = ((X_W + 1)'(x0) + (X_W + 1)'(j) < (X_W + 1)'(mbb_pkg::DISP_WIDTH)) &&
                !(cfg.transparent_mode && req.src_byte[mbb_pkg::BYTE_W-1-j]);
    end

    res.base_address  = base_full[mbb_pkg::ADDR_W-1:0];
    res.pixels        = mbb_pkg::expand_pixels(req.src_byte);
    res.write_mask    = (in_image && row_visible) ? mask : '0;
    res.last_of_image = in_image &&
      (({1'b0, req.column} + 1'b1) == {1'b0, cfg.image_width_bytes}) &&
      (({1'b0, req.row} + 1'b1) == {1'b0, cfg.image_height});
  end

endmodule

// ===== src/mono_bitmap_blit_clipped.sv =====
// ----------------------------------------------------------------------------
// mono_bitmap_blit_clipped
// Expands a 1-bit source image into clipped 2-bit framebuffer write requests.
// ----------------------------------------------------------------------------
// Stages: request register, then result register. Throughput: one source
//   byte per clock while the sink is ready; the path that sets the clock is
//   the address multiply-add (row times display width) in mbb_calc.
// Reset (rst, synchronous): clears both pipeline valids, the position counters
//   and all configuration registers.
`include "assert_macros.svh"

module mono_bitmap_blit_clipped (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mbb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mbb_pkg::CFG_DATA_W-1:0]   cfg_data,
  mbb_src_if.sink                          src,
  mbb_dst_if.source                        dst
);

  mbb_pkg::cfg_t cfg;

  // Request stage: captured byte and its position.
  logic          req_valid;
  mbb_pkg::req_t req;

  // Result stage.
  logic          res_valid;
  mbb_pkg::res_t res;
  mbb_pkg::res_t res_next;

  logic [mbb_pkg::COL_W-1:0] column;
  logic [mbb_pkg::ROW_W-1:0] row;

  logic src_acc;
  logic res_adv;
  logic cfg_empty;

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (mbb_pkg::reg_idx_t'(cfg_index))
        mbb_pkg::REG_ORIGIN_X:    cfg.origin_x          <= cfg_data;
        mbb_pkg::REG_ORIGIN_Y:    cfg.origin_y          <= cfg_data;
        mbb_pkg::REG_WIDTH_BYTES: cfg.image_width_bytes <= cfg_data[mbb_pkg::COL_W-1:0];
        mbb_pkg::REG_HEIGHT:      cfg.image_height      <= cfg_data[mbb_pkg::ROW_W-1:0];
        mbb_pkg::REG_TRANSPARENT: cfg.transparent_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Result register advances when empty or when the sink takes it; the
  // request stage refills whenever it drains into the result stage.
  assign res_adv   = !res_valid || dst.ready;
  assign src.ready = !req_valid || res_adv;
  assign src_acc   = src.valid && src.ready;
  assign cfg_empty = (cfg.image_width_bytes == '0) || (cfg.image_height == '0);

  // Position of the next source byte; advance on every accepted request.
  mbb_ctr u_ctr (
    .clk     (clk),
    .rst     (rst),
    .advance (src_acc),
    .cfg     (cfg),
    .column  (column),
    .row     (row)
  );

  // Capture the byte with the position it belongs to (pre-increment).
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (src.ready) begin
      req_valid <= src.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src_acc) begin
      req.src_byte <= src.src_byte;
      req.column   <= column;
      req.row      <= row;
    end
  end

  mbb_calc u_calc (
    .req (req),
    .cfg (cfg),
    .res (res_next)
  );

  // Hold the finished request until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_adv) begin
      res_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_adv && req_valid) begin
      res <= res_next;
    end
  end

  assign dst.valid         = res_valid;
  assign dst.base_address  = res.base_address;
  assign dst.pixels        = res.pixels;
  assign dst.write_mask    = res.write_mask;
  assign dst.last_of_image = res.last_of_image;

  // A captured request is never dropped while the result stage is stalled.
  `MBB_ASSERT_NEXT(a_req_held, clk, rst, req_valid && !res_adv, req_valid && $stable(req))

  // After a step with a non-empty image, the column lies inside the image row.
  `MBB_ASSERT_NEXT(a_pos_in_bounds, clk, rst, src_acc && !cfg_empty && !cfg_we, column < cfg.image_width_bytes)

  // An empty image keeps the counters at the origin.
  `MBB_ASSERT_NEXT(a_empty_zero, clk, rst, src_acc && cfg_empty && !cfg_we, (column == '0) && (row == '0))

endmodule
